FILE: hdl/pbrf_pkg.sv
// pbrf_pkg: shared types, constants and the piece letter lookup
// for the packed board record to FEN converter.
// No dependencies.
package pbrf_pkg;

	localparam int RECORD_BYTES = 32;

	typedef logic [4:0] byte_addr_t;
	typedef logic [3:0] piece_code_t;

	localparam byte_addr_t OCC_LAST_ADDR    = 5'd7;
	localparam byte_addr_t PIECE_LAST_ADDR  = 5'd23;
	localparam byte_addr_t SCORE_LO_ADDR    = 5'd24;
	localparam byte_addr_t SCORE_HI_ADDR    = 5'd25;
	localparam byte_addr_t OUTCOME_ADDR     = 5'd26;
	localparam byte_addr_t RECORD_LAST_ADDR = 5'd31;

	localparam piece_code_t EMPTY_CODE = 4'h7;

	localparam logic [1:0] REG_SKIP_STRIDE  = 2'd0;
	localparam logic [1:0] REG_RECORD_LIMIT = 2'd1;

	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] LOWER_BIT  = 8'h20;

	typedef struct packed {
		logic [3:0]  char_count;
		logic [63:0] text;
	} rank_text_t;

	// 0 means no piece (empty square, including type codes 6 and 7)
	function automatic logic [7:0] code_letter(piece_code_t code);
		logic [7:0] ch;
		case (code[2:0])
			3'd0: ch = 8'h50;
			3'd1: ch = 8'h4E;
			3'd2: ch = 8'h42;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h51;
			3'd5: ch = 8'h4B;
			default: ch = 8'h00;
		endcase
		if (code[3] && ch != 8'h00) begin
			ch = ch | LOWER_BIT;
		end
		return ch;
	endfunction

endpackage

FILE: hdl/packed_board_record_to_fen.sv
// packed_board_record_to_fen: top level, 32-byte record buffer in RAM, board decoder.
// Depends on pbrf_pkg, pbrf_ram, pbrf_rank_fmt.
// Bytes transfer one per cycle while the block is idle. After the last byte of a kept
// record the input stalls while the buffer is read to the outcome byte, the squares
// are placed and the eight ranks go out, one per cycle unless the output stalls.
// Records that are skipped or over the limit cost nothing beyond their 32 bytes.
// Reset clears counters and handshakes; the RAM and data registers are not cleared.
module packed_board_record_to_fen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               record_valid,
	output logic               record_ready,
	input  logic [7:0]         record_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         rank_number,
	output logic [3:0]         char_count,
	output logic [63:0]        rank_text,
	output logic signed [15:0] eval_score,
	output logic [7:0]         game_outcome,
	output logic               last_rank
);
	import pbrf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LOAD_WAIT,
		ST_PLACE,
		ST_EMIT
	} state_t;

	state_t      state_q;
	byte_addr_t  byte_pos_q;
	byte_addr_t  rd_addr_q;
	byte_addr_t  ld_addr_s1;
	logic        ld_vld_s1;
	logic [7:0]  rd_data;
	logic [31:0] skip_stride_q;
	logic [31:0] record_limit_q;
	logic [31:0] stride_phase_q;
	logic [31:0] emitted_q;
	logic [5:0]  sq_q;
	logic [5:0]  pcnt_q;
	logic [2:0]  rank_q;
	logic [63:0] occ_q;
	logic [127:0] piece_q;
	logic [255:0] board_q;
	logic [15:0] score_q;
	logic [7:0]  outcome_q;
	logic        result_valid_q;
	logic [2:0]  rank_number_q;
	logic [3:0]  char_count_q;
	logic [63:0] rank_text_q;
	logic [15:0] eval_score_q;
	logic [7:0]  game_outcome_q;
	logic        last_rank_q;

	logic        rec_xfer;
	logic [31:0] stride_eff;
	logic        phase_wrap;
	logic        keep;
	logic        limit_hit;
	logic        take_piece;
	piece_code_t place_code;
	logic        emit_fire;
	rank_text_t  fmt;

	assign record_ready = (state_q == ST_IDLE);
	assign rec_xfer     = record_valid && record_ready;
	assign stride_eff   = (skip_stride_q == 32'd0) ? 32'd1 : skip_stride_q;
	assign phase_wrap   = ({1'b0, stride_phase_q} + 33'd1) >= {1'b0, stride_eff};
	assign keep         = (stride_phase_q == 32'd0);
	assign limit_hit    = (record_limit_q != 32'd0) && (emitted_q >= record_limit_q);
	assign take_piece   = occ_q[0] && !pcnt_q[5];
	assign place_code   = take_piece ? piece_q[3:0] : EMPTY_CODE;
	assign emit_fire    = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	pbrf_ram #(
		.WIDTH(8),
		.DEPTH(RECORD_BYTES)
	) u_buf (
		.clk     (clk),
		.wr_en   (rec_xfer),
		.wr_addr (byte_pos_q),
		.wr_data (record_byte),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	pbrf_rank_fmt u_fmt (
		.squares (board_q[255:224]),
		.fmt     (fmt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			byte_pos_q     <= '0;
			rd_addr_q      <= '0;
			ld_vld_s1      <= 1'b0;
			skip_stride_q  <= 32'd1;
			record_limit_q <= 32'd0;
			stride_phase_q <= 32'd0;
			emitted_q      <= 32'd0;
			sq_q           <= 6'd0;
			pcnt_q         <= 6'd0;
			rank_q         <= 3'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SKIP_STRIDE:  skip_stride_q  <= cfg_data;
					REG_RECORD_LIMIT: record_limit_q <= cfg_data;
					default: ;
				endcase
			end
			ld_vld_s1 <= (state_q == ST_LOAD);
			if (emit_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rec_xfer) begin
						byte_pos_q <= byte_pos_q + 5'd1;
						if (byte_pos_q == RECORD_LAST_ADDR) begin
							stride_phase_q <= phase_wrap ? 32'd0 : stride_phase_q + 32'd1;
							if (keep && !limit_hit) begin
								state_q   <= ST_LOAD;
								rd_addr_q <= '0;
								if (emitted_q != 32'hFFFF_FFFF) begin
									emitted_q <= emitted_q + 32'd1;
								end
							end
						end
					end
				end
				ST_LOAD: begin
					rd_addr_q <= rd_addr_q + 5'd1;
					if (rd_addr_q == OUTCOME_ADDR) begin
						state_q <= ST_LOAD_WAIT;
					end
				end
				ST_LOAD_WAIT: begin
					state_q <= ST_PLACE;
					sq_q    <= 6'd0;
					pcnt_q  <= 6'd0;
				end
				ST_PLACE: begin
					sq_q <= sq_q + 6'd1;
					if (take_piece) begin
						pcnt_q <= pcnt_q + 6'd1;
					end
					if (sq_q == 6'd63) begin
						state_q <= ST_EMIT;
						rank_q  <= 3'd7;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						rank_q <= rank_q - 3'd1;
						if (rank_q == 3'd0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// record fields are shifted in as they come out of the buffer
	always_ff @(posedge clk) begin
		ld_addr_s1 <= rd_addr_q;
		if (ld_vld_s1) begin
			if (ld_addr_s1 <= OCC_LAST_ADDR) begin
				occ_q <= {rd_data, occ_q[63:8]};
			end else if (ld_addr_s1 <= PIECE_LAST_ADDR) begin
				piece_q <= {rd_data, piece_q[127:8]};
			end else if (ld_addr_s1 == SCORE_LO_ADDR) begin
				score_q[7:0] <= rd_data;
			end else if (ld_addr_s1 == SCORE_HI_ADDR) begin
				score_q[15:8] <= rd_data;
			end else if (ld_addr_s1 == OUTCOME_ADDR) begin
				outcome_q <= rd_data;
			end
		end
		if (state_q == ST_PLACE) begin
			occ_q   <= {1'b0, occ_q[63:1]};
			board_q <= {place_code, board_q[255:4]};
			if (take_piece) begin
				piece_q <= {4'h0, piece_q[127:4]};
			end
		end
		if (emit_fire) begin
			board_q        <= {board_q[223:0], 32'h0};
			rank_number_q  <= rank_q;
			char_count_q   <= fmt.char_count;
			rank_text_q    <= fmt.text;
			eval_score_q   <= score_q;
			game_outcome_q <= outcome_q;
			last_rank_q    <= (rank_q == 3'd0);
		end
	end

	assign result_valid = result_valid_q;
	assign rank_number  = rank_number_q;
	assign char_count   = char_count_q;
	assign rank_text    = rank_text_q;
	assign eval_score   = eval_score_q;
	assign game_outcome = game_outcome_q;
	assign last_rank    = last_rank_q;

endmodule

FILE: hdl/pbrf_ram.sv
// pbrf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hdl/pbrf_rank_fmt.sv
// pbrf_rank_fmt: formats eight square codes of one rank into FEN placement text.
// Depends on pbrf_pkg.
module pbrf_rank_fmt (
	input  logic [31:0]          squares,
	output pbrf_pkg::rank_text_t fmt
);
	import pbrf_pkg::*;

	logic [7:0] txt [8];
	logic [3:0] len;
	logic [3:0] run;
	logic [7:0] ch;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			txt[i] = 8'h00;
		end
		len = 4'd0;
		run = 4'd0;
		ch  = 8'h00;
		for (int f = 0; f < 8; f++) begin
			ch = code_letter(squares[f*4 +: 4]);
			if (ch == 8'h00) begin
				run = run + 4'd1;
			end else begin
				if (run != 4'd0) begin
					txt[len[2:0]] = DIGIT_ZERO + {4'h0, run};
					len = len + 4'd1;
					run = 4'd0;
				end
				txt[len[2:0]] = ch;
				len = len + 4'd1;
			end
		end
		if (run != 4'd0) begin
			txt[len[2:0]] = DIGIT_ZERO + {4'h0, run};
			len = len + 4'd1;
		end
		fmt.char_count = len;
		fmt.text = {txt[7], txt[6], txt[5], txt[4], txt[3], txt[2], txt[1], txt[0]};
	end

endmodule
